// File: sv/cau_pkg.sv
// Shared types, codes and saturation helpers for the complex arithmetic unit.
// No dependencies; every other file imports this package.
package cau_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int QUO_W     = DATA_W + 1;
    localparam int REM_W     = PROD_W + DATA_W;
    localparam int NUM_CELLS = QUO_W;

    localparam logic [2:0] CMD_ADD  = 3'd0;
    localparam logic [2:0] CMD_SUB  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_CONJ = 3'd4;

    typedef struct packed {
        logic [2:0]                cmd;
        logic signed [DATA_W-1:0]  ar;
        logic signed [DATA_W-1:0]  ai;
        logic signed [DATA_W-1:0]  br;
        logic signed [DATA_W-1:0]  bi;
        logic signed [PROD_W-1:0]  p_rr;
        logic signed [PROD_W-1:0]  p_ii;
        logic signed [PROD_W-1:0]  p_ir;
        logic signed [PROD_W-1:0]  p_ri;
        logic [PROD_W-1:0]         p_br2;
        logic [PROD_W-1:0]         p_bi2;
    } t_prod;

    typedef struct packed {
        logic                      is_div;
        logic                      dz;
        logic                      neg_re;
        logic                      neg_im;
        logic [REM_W-1:0]          r_re;
        logic [REM_W-1:0]          r_im;
        logic [REM_W-1:0]          ds;
        logic [QUO_W-1:0]          q_re;
        logic [QUO_W-1:0]          q_im;
        logic [DATA_W-1:0]         re;
        logic [DATA_W-1:0]         im;
        logic                      ovf;
    } t_div;

    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic              ovf;
    } t_sat;

    // Saturate a sign-magnitude value to a signed 32-bit word.
    function automatic t_sat sat_sm(input logic neg, input logic [PROD_W-1:0] mag);
        t_sat res;
        res.ovf = 1'b0;
        if (!neg) begin
            if (mag > PROD_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
                res.val = {1'b0, {(DATA_W-1){1'b1}}};
                res.ovf = 1'b1;
            end else begin
                res.val = mag[DATA_W-1:0];
            end
        end else begin
            if (mag > PROD_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
                res.val = {1'b1, {(DATA_W-1){1'b0}}};
                res.ovf = 1'b1;
            end else begin
                res.val = DATA_W'(~mag + 1'b1);
            end
        end
        return res;
    endfunction

    // Saturate a 33-bit two's complement value to 32 bits.
    function automatic t_sat sat_s33(input logic [DATA_W:0] v);
        t_sat res;
        if (v[DATA_W] != v[DATA_W-1]) begin
            res.ovf = 1'b1;
            res.val = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
                                : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            res.ovf = 1'b0;
            res.val = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// File: sv/cau_mul.sv
// First pipeline stage: registers the operands and the six partial products.
// Depends on cau_pkg.
module cau_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [2:0]                  i_cmd,
    input  logic signed [cau_pkg::DATA_W-1:0] i_ar,
    input  logic signed [cau_pkg::DATA_W-1:0] i_ai,
    input  logic signed [cau_pkg::DATA_W-1:0] i_br,
    input  logic signed [cau_pkg::DATA_W-1:0] i_bi,
    output logic                        o_valid,
    input  logic                        i_ready,
    output cau_pkg::t_prod              o_data
);
    import cau_pkg::*;

    logic  r_valid;
    t_prod r_data;
    t_prod n_data;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data.cmd   = i_cmd;
        n_data.ar    = i_ar;
        n_data.ai    = i_ai;
        n_data.br    = i_br;
        n_data.bi    = i_bi;
        n_data.p_rr  = PROD_W'(i_ar * i_br);
        n_data.p_ii  = PROD_W'(i_ai * i_bi);
        n_data.p_ir  = PROD_W'(i_ai * i_br);
        n_data.p_ri  = PROD_W'(i_ar * i_bi);
        n_data.p_br2 = PROD_W'(i_br * i_br);
        n_data.p_bi2 = PROD_W'(i_bi * i_bi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: sv/cau_prep.sv
// Second stage: forms the sums of products, finishes add, subtract, multiply
// and conjugate, and sets up dividend and divisor for the cell chain. Uses cau_pkg.
module cau_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  cau_pkg::t_prod i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output cau_pkg::t_div  o_data
);
    import cau_pkg::*;

    logic                 r_valid;
    t_div                 r_data;
    t_div                 n_data;
    logic [PROD_W:0]      s_re;
    logic [PROD_W:0]      s_im;
    logic [PROD_W-1:0]    mag_re;
    logic [PROD_W-1:0]    mag_im;
    logic [PROD_W-1:0]    den;
    t_sat                 sat_re;
    t_sat                 sat_im;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        if (i_data.cmd == CMD_DIV) begin
            s_re = {i_data.p_rr[PROD_W-1], i_data.p_rr} + {i_data.p_ii[PROD_W-1], i_data.p_ii};
            s_im = {i_data.p_ir[PROD_W-1], i_data.p_ir} - {i_data.p_ri[PROD_W-1], i_data.p_ri};
        end else begin
            s_re = {i_data.p_rr[PROD_W-1], i_data.p_rr} - {i_data.p_ii[PROD_W-1], i_data.p_ii};
            s_im = {i_data.p_ir[PROD_W-1], i_data.p_ir} + {i_data.p_ri[PROD_W-1], i_data.p_ri};
        end
        mag_re = s_re[PROD_W] ? PROD_W'(~s_re + 1'b1) : s_re[PROD_W-1:0];
        mag_im = s_im[PROD_W] ? PROD_W'(~s_im + 1'b1) : s_im[PROD_W-1:0];
        den    = i_data.p_br2 + i_data.p_bi2;

        sat_re = '0;
        sat_im = '0;
        unique case (i_data.cmd)
            CMD_ADD: begin
                sat_re = sat_s33({i_data.ar[DATA_W-1], i_data.ar}
                                 + {i_data.br[DATA_W-1], i_data.br});
                sat_im = sat_s33({i_data.ai[DATA_W-1], i_data.ai}
                                 + {i_data.bi[DATA_W-1], i_data.bi});
            end
            CMD_SUB: begin
                sat_re = sat_s33({i_data.ar[DATA_W-1], i_data.ar}
                                 - {i_data.br[DATA_W-1], i_data.br});
                sat_im = sat_s33({i_data.ai[DATA_W-1], i_data.ai}
                                 - {i_data.bi[DATA_W-1], i_data.bi});
            end
            CMD_MUL: begin
                sat_re = sat_sm(s_re[PROD_W], mag_re >> FRAC_BITS);
                sat_im = sat_sm(s_im[PROD_W], mag_im >> FRAC_BITS);
            end
            CMD_CONJ: begin
                sat_re.val = i_data.ar;
                sat_re.ovf = 1'b0;
                sat_im = sat_s33((DATA_W+1)'(0) - {i_data.ai[DATA_W-1], i_data.ai});
            end
            default: begin
                sat_re = '0;
                sat_im = '0;
            end
        endcase

        n_data.is_div = (i_data.cmd == CMD_DIV);
        n_data.dz     = (i_data.br == '0) && (i_data.bi == '0);
        n_data.neg_re = s_re[PROD_W];
        n_data.neg_im = s_im[PROD_W];
        n_data.r_re   = REM_W'(mag_re) << FRAC_BITS;
        n_data.r_im   = REM_W'(mag_im) << FRAC_BITS;
        n_data.ds     = {den, {DATA_W{1'b0}}};
        n_data.q_re   = '0;
        n_data.q_im   = '0;
        n_data.re     = sat_re.val;
        n_data.im     = sat_im.val;
        n_data.ovf    = sat_re.ovf | sat_im.ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: sv/cau_cell.sv
// One restoring-division cell: produces one quotient bit for both parts and
// halves the shifted divisor for its neighbor. Uses cau_pkg.
module cau_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  cau_pkg::t_div i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output cau_pkg::t_div o_data
);
    import cau_pkg::*;

    logic r_valid;
    t_div r_data;
    t_div n_data;
    logic ge_re;
    logic ge_im;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_data = i_data;
        ge_re  = i_data.r_re >= i_data.ds;
        ge_im  = i_data.r_im >= i_data.ds;
        if (ge_re) begin
            n_data.r_re = i_data.r_re - i_data.ds;
        end
        if (ge_im) begin
            n_data.r_im = i_data.r_im - i_data.ds;
        end
        n_data.q_re = {i_data.q_re[QUO_W-2:0], ge_re};
        n_data.q_im = {i_data.q_im[QUO_W-2:0], ge_im};
        n_data.ds   = i_data.ds >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// File: sv/cau_out.sv
// Output stage: picks the divide or direct result, saturates quotients and
// holds the result register. Uses cau_pkg.
module cau_out (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  cau_pkg::t_div             i_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [cau_pkg::DATA_W-1:0] o_re,
    output logic [cau_pkg::DATA_W-1:0] o_im,
    output logic                      o_dz,
    output logic                      o_ovf
);
    import cau_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_re;
    logic [DATA_W-1:0] r_im;
    logic              r_dz;
    logic              r_ovf;
    logic [DATA_W-1:0] n_re;
    logic [DATA_W-1:0] n_im;
    logic              n_dz;
    logic              n_ovf;
    t_sat              q_re;
    t_sat              q_im;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        q_re = sat_sm(i_data.neg_re, PROD_W'(i_data.q_re));
        q_im = sat_sm(i_data.neg_im, PROD_W'(i_data.q_im));
        priority if (i_data.is_div && i_data.dz) begin
            n_re  = '0;
            n_im  = '0;
            n_dz  = 1'b1;
            n_ovf = 1'b0;
        end else if (i_data.is_div) begin
            n_re  = q_re.val;
            n_im  = q_im.val;
            n_dz  = 1'b0;
            n_ovf = q_re.ovf | q_im.ovf;
        end else begin
            n_re  = i_data.re;
            n_im  = i_data.im;
            n_dz  = 1'b0;
            n_ovf = i_data.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_dz  <= n_dz;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_re    = r_re;
    assign o_im    = r_im;
    assign o_dz    = r_dz;
    assign o_ovf   = r_ovf;
endmodule

// File: sv/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: multiply stage, preparation stage,
// a chain of division cells and the output register. Uses cau_pkg.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+------------------------------------
//   in      | to unit   | i_in_valid / o_in_ready   | i_cmd, i_a_real, i_a_imag, i_b_real, i_b_imag
//   out     | from unit | o_out_valid / i_out_ready | o_res_real, o_res_imag, o_div_zero, o_overflow
//
// Every item, whatever its opcode, travels the same pipeline of 36 registered
// stages. The input transfer loads the first stage, and one item can be taken
// in every cycle while the output is not stalled. The 33 division cells each
// settle one quotient bit per cycle while not stalled; the top bit only
// reports a quotient too large for 32 bits.
// Each stage holds its item until the next one can take it, so a stall at the
// output fills bubbles first and then stops the input. Reset clears only the
// stage valid bits, and no clearing pass is needed.
module complex_arithmetic_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [2:0]                         i_cmd,
    input  logic signed [cau_pkg::DATA_W-1:0]  i_a_real,
    input  logic signed [cau_pkg::DATA_W-1:0]  i_a_imag,
    input  logic signed [cau_pkg::DATA_W-1:0]  i_b_real,
    input  logic signed [cau_pkg::DATA_W-1:0]  i_b_imag,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [cau_pkg::DATA_W-1:0]  o_res_real,
    output logic signed [cau_pkg::DATA_W-1:0]  o_res_imag,
    output logic                               o_div_zero,
    output logic                               o_overflow
);
    import cau_pkg::*;

    // Handshake between the multiply stage and the preparation stage.
    logic  mul_valid;
    logic  prep_ready;
    t_prod mul_data;

    // Link k feeds cell k; link NUM_CELLS feeds the output stage.
    logic  link_valid [NUM_CELLS+1];
    logic  link_ready [NUM_CELLS+1];
    t_div  link_data  [NUM_CELLS+1];

    logic [DATA_W-1:0] res_re;
    logic [DATA_W-1:0] res_im;

    cau_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_cmd   (i_cmd),
        .i_ar    (i_a_real),
        .i_ai    (i_a_imag),
        .i_br    (i_b_real),
        .i_bi    (i_b_imag),
        .o_valid (mul_valid),
        .i_ready (prep_ready),
        .o_data  (mul_data)
    );

    // The preparation stage finishes every opcode but divide and loads the
    // dividend magnitudes and the divisor, shifted up by 32, into the chain.
    cau_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (prep_ready),
        .i_data  (mul_data),
        .o_valid (link_valid[0]),
        .i_ready (link_ready[0]),
        .o_data  (link_data[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        cau_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[k]),
            .o_ready (link_ready[k]),
            .i_data  (link_data[k]),
            .o_valid (link_valid[k+1]),
            .i_ready (link_ready[k+1]),
            .o_data  (link_data[k+1])
        );
    end

    // The output stage is the result register seen on the out channel.
    cau_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (link_valid[NUM_CELLS]),
        .o_ready (link_ready[NUM_CELLS]),
        .i_data  (link_data[NUM_CELLS]),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_re    (res_re),
        .o_im    (res_im),
        .o_dz    (o_div_zero),
        .o_ovf   (o_overflow)
    );

    assign o_res_real = res_re;
    assign o_res_imag = res_im;
endmodule
